FILE: src/bsu_pkg.sv
// Package for the bounding sphere union block: word types, widths and helpers.
// Used by the top level and the checker; depends on nothing.
package bsu_pkg;

    // coordinate and radius widths (signed Q16.16 coordinates)
    localparam int CW     = 32;
    localparam int RAD_W  = CW - 1;
    // center difference, squared distance and distance widths
    localparam int DIF_W  = CW + 1;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int ROOT_N = DIF_W;
    localparam int DIST_W = ROOT_N + 1;
    // numerator product, divider numerator, divisor and quotient widths
    localparam int PROD_W = DIF_W + DIST_W + 1;
    localparam int NUM_W  = PROD_W - 1;
    localparam int DEN_W  = DIST_W + 1;
    localparam int QUO_W  = CW + 2;

    typedef struct packed {
        logic signed [CW-1:0] a_center_x;
        logic signed [CW-1:0] a_center_y;
        logic signed [CW-1:0] a_center_z;
        logic [RAD_W-1:0]     a_radius;
        logic signed [CW-1:0] b_center_x;
        logic signed [CW-1:0] b_center_y;
        logic signed [CW-1:0] b_center_z;
        logic [RAD_W-1:0]     b_radius;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] union_center_x;
        logic signed [CW-1:0] union_center_y;
        logic signed [CW-1:0] union_center_z;
        logic [RAD_W-1:0]     union_radius;
    } t_out;

    // side data that rides along the x divider
    typedef struct packed {
        t_in              data;
        logic             dzero;
        logic [RAD_W-1:0] rad;
        logic             neg;
    } t_tail;

    typedef logic [2:0][CW-1:0] t_vec;

    // centers as vectors, index 0 is x
    function automatic t_vec center_a(t_in w);
        return {w.a_center_z, w.a_center_y, w.a_center_x};
    endfunction

    function automatic t_vec center_b(t_in w);
        return {w.b_center_z, w.b_center_y, w.b_center_x};
    endfunction

endpackage

FILE: src/bsu_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// Standalone; carries a side word alongside each value.
module bsu_sqrt #(
    parameter int N      = 33,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*N-1:0]    i_sq,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N:0]        o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int RW = N + 3;

    logic              r_v    [N+1];
    logic [2*N-1:0]    r_sq   [N+1];
    logic [RW-1:0]     r_rem  [N+1];
    logic [N-1:0]      r_root [N+1];
    logic [SIDE_W-1:0] r_side [N+1];
    logic [RW-1:0]     n_rem  [N];
    logic [N-1:0]      n_root [N];
    logic              r_fv;
    logic [N:0]        r_froot;
    logic [SIDE_W-1:0] r_fside;

    // one result bit per stage: try root*4+1 against the remainder
    always_comb begin
        logic [RW-1:0] cur [N];
        logic [RW-1:0] trial [N];
        for (int k = 0; k < N; k++) begin
            cur[k]   = {r_rem[k][RW-3:0], r_sq[k][2*N-1-2*k -: 2]};
            trial[k] = {1'b0, r_root[k], 2'b01};
            if (cur[k] >= trial[k]) begin
                n_rem[k]  = cur[k] - trial[k];
                n_root[k] = {r_root[k][N-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[k];
                n_root[k] = {r_root[k][N-2:0], 1'b0};
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_v[k] <= 1'b0;
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < N; k++) r_v[k+1] <= r_v[k];
            r_fv <= r_v[N];
        end
    end

    // advance data; round up when the remainder exceeds the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0]   <= i_sq;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int k = 0; k < N; k++) begin
                r_sq[k+1]   <= r_sq[k];
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
                r_side[k+1] <= r_side[k];
            end
            r_froot <= {1'b0, r_root[N]}
                     + (N+1)'(r_rem[N] > {3'b000, r_root[N]});
            r_fside <= r_side[N];
        end
    end

    assign o_valid = r_fv;
    assign o_root  = r_froot;
    assign o_side  = r_fside;
endmodule

FILE: src/bsu_div.sv
// Pipelined restoring divider, one quotient bit per stage, floor quotient.
// Standalone; carries a side word alongside each value.
module bsu_div #(
    parameter int NW     = 67,
    parameter int DW     = 35,
    parameter int QW     = 34,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quo,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_v    [QW+1];
    logic [DW-1:0]     r_rem  [QW+1];
    logic [QW-1:0]     r_lo   [QW+1];
    logic [QW-1:0]     r_q    [QW+1];
    logic [DW-1:0]     r_den  [QW+1];
    logic [SIDE_W-1:0] r_side [QW+1];
    logic [DW-1:0]     n_rem  [QW];
    logic [QW-1:0]     n_q    [QW];

    // shift in one numerator bit, subtract the divisor when it fits
    always_comb begin
        logic [DW:0] cur [QW];
        logic [DW:0] dif [QW];
        for (int k = 0; k < QW; k++) begin
            cur[k] = {r_rem[k], r_lo[k][QW-1-k]};
            dif[k] = cur[k] - {1'b0, r_den[k]};
            if (cur[k] >= {1'b0, r_den[k]}) begin
                n_rem[k] = dif[k][DW-1:0];
                n_q[k]   = {r_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = cur[k][DW-1:0];
                n_q[k]   = {r_q[k][QW-2:0], 1'b0};
            end
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QW; k++) r_v[k+1] <= r_v[k];
        end
    end

    // advance data; the high numerator part is already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {{(DW-(NW-QW)){1'b0}}, i_num[NW-1:QW]};
            r_lo[0]   <= i_num[QW-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_lo[k+1]   <= r_lo[k];
                r_q[k+1]    <= n_q[k];
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_side  = r_side[QW];
endmodule

FILE: src/bounding_sphere_union.sv
// Top level of the bounding sphere union: merges two spheres into one.
// Depends on bsu_pkg, bsu_sqrt and bsu_div.
//
//  channel | valid       | ready       | word
//  in      | i_in_valid  | o_in_ready  | i_in_data  (t_in)
//  out     | o_out_valid | i_out_ready | o_out_data (t_out)
//
// One word is accepted every cycle while the skid register is empty; the result
// word passes 77 register stages, set by the 35-stage square root and the
// 35-stage dividers.
// Reset clears only valid bits; a synchronous low i_rst_n empties the pipeline.
// A stalled output parks one result in a skid register; the whole pipeline
// holds while that register is full, so nothing is lost or repeated.
module bounding_sphere_union import bsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam int TAIL_W = $bits(t_tail);

    logic en;

    // stage 1: differences and squares
    logic                r1_v;
    t_in                 r1_d;
    logic [SQ_W-1:0]     r1_sq [3];
    logic [SQ_W-1:0]     n1_sq [3];
    // stage 2: squared distance
    logic                r2_v;
    t_in                 r2_d;
    logic [SQ_W-1:0]     r2_s;
    // square root output
    logic                sq_v;
    logic [DIST_W-1:0]   sq_dist;
    t_in                 sq_d;
    // stage 3: pushed-out radii
    logic                r3_v;
    t_in                 r3_d;
    logic [DIST_W-1:0]   r3_dist;
    logic [RAD_W-1:0]    r3_ma, r3_mb;
    logic [RAD_W-1:0]    n3_ma, n3_mb;
    // stage 4: offset factor, radius, sums and differences
    logic                r4_v;
    t_in                 r4_d;
    logic [DIST_W-1:0]   r4_dist;
    logic [CW-1:0]       r4_k;
    logic [RAD_W-1:0]    r4_rad;
    logic [DIF_W-1:0]    r4_sum [3];
    logic [DIF_W-1:0]    r4_dif [3];
    logic [DIST_W:0]     n4_rsum;
    logic [DIST_W-1:0]   n4_rhalf;
    // stage 5: products
    logic                r5_v;
    t_in                 r5_d;
    logic [DIST_W-1:0]   r5_dist;
    logic [RAD_W-1:0]    r5_rad;
    logic [PROD_W-1:0]   r5_p1 [3];
    logic [DIF_W+CW-1:0] r5_p2 [3];
    // stage 6: numerators
    logic                r6_v;
    t_in                 r6_d;
    logic [DIST_W-1:0]   r6_dist;
    logic [RAD_W-1:0]    r6_rad;
    logic [PROD_W-1:0]   r6_n [3];
    // divider interface
    logic [PROD_W-1:0]   dv_m  [3];
    logic [NUM_W-1:0]    dv_num [3];
    logic [DEN_W-1:0]    dv_den;
    t_tail               dv_tail;
    logic                q_v;
    logic                q_vx, q_vy, q_vz;
    logic [QUO_W-1:0]    q_quo [3];
    t_tail               q_tail;
    logic                q_negy, q_negz;
    // tail and output
    logic [2:0][CW-1:0]  fin_c;
    t_out                fin_w;
    logic                r_out_valid;
    t_out                r_out_data;
    logic                r_skid_valid;
    t_out                r_skid_data;
    logic                push;
    logic                space;

    // hold the pipeline while the skid register is full
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // square the center differences
    always_comb begin
        t_vec             ca, cb;
        logic [DIF_W-1:0] df [3];
        logic [DIF_W-1:0] mg [3];
        ca = center_a(i_in_data);
        cb = center_b(i_in_data);
        for (int i = 0; i < 3; i++) begin
            df[i]    = {ca[i][CW-1], ca[i]} - {cb[i][CW-1], cb[i]};
            mg[i]    = df[i][DIF_W-1] ? -df[i] : df[i];
            n1_sq[i] = SQ_W'(mg[i]) * SQ_W'(mg[i]);
        end
    end

    // pushed-out radii: max(ra, rb - d) and max(rb, ra - d)
    always_comb begin
        logic signed [DIST_W:0] ra_s, rb_s, rbd, rad_d;
        ra_s  = $signed({{(DIST_W+1-RAD_W){1'b0}}, sq_d.a_radius});
        rb_s  = $signed({{(DIST_W+1-RAD_W){1'b0}}, sq_d.b_radius});
        rbd   = rb_s - $signed({1'b0, sq_dist});
        rad_d = ra_s - $signed({1'b0, sq_dist});
        n3_ma = (rbd > ra_s) ? rbd[RAD_W-1:0] : sq_d.a_radius;
        n3_mb = (rad_d > rb_s) ? rad_d[RAD_W-1:0] : sq_d.b_radius;
    end

    // radius: (d + ma + mb + 1) / 2, clamped
    assign n4_rsum  = {1'b0, r3_dist} + {{(DIST_W+1-RAD_W){1'b0}}, r3_ma}
                    + {{(DIST_W+1-RAD_W){1'b0}}, r3_mb} + (DIST_W+1)'(1);
    assign n4_rhalf = n4_rsum[DIST_W:1];

    // numerator is biased by d so that the floor divide rounds to nearest
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_m[i]   = (r6_n[i][PROD_W-1] ? ~r6_n[i] : r6_n[i])
                      + {{(PROD_W-DIST_W){1'b0}}, r6_dist}
                      + PROD_W'(r6_n[i][PROD_W-1]);
            dv_num[i] = dv_m[i][NUM_W-1:0];
        end
    end
    assign dv_den        = {r6_dist, 1'b0};
    assign dv_tail.data  = r6_d;
    assign dv_tail.dzero = (r6_dist == '0);
    assign dv_tail.rad   = r6_rad;
    assign dv_tail.neg   = r6_n[0][PROD_W-1];

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= sq_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // advance data through the arithmetic stages
    always_ff @(posedge i_clk) begin
        t_vec ca, cb;
        ca = center_a(r3_d);
        cb = center_b(r3_d);
        if (en) begin
            r1_d <= i_in_data;
            for (int i = 0; i < 3; i++) r1_sq[i] <= n1_sq[i];
            r2_d <= r1_d;
            r2_s <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r3_d    <= sq_d;
            r3_dist <= sq_dist;
            r3_ma   <= n3_ma;
            r3_mb   <= n3_mb;
            r4_d    <= r3_d;
            r4_dist <= r3_dist;
            r4_k    <= {1'b0, r3_ma} - {1'b0, r3_mb};
            r4_rad  <= (n4_rhalf > {{(DIST_W-RAD_W){1'b0}}, {RAD_W{1'b1}}})
                     ? {RAD_W{1'b1}} : n4_rhalf[RAD_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r4_sum[i] <= {ca[i][CW-1], ca[i]} + {cb[i][CW-1], cb[i]};
                r4_dif[i] <= {ca[i][CW-1], ca[i]} - {cb[i][CW-1], cb[i]};
            end
            r5_d    <= r4_d;
            r5_dist <= r4_dist;
            r5_rad  <= r4_rad;
            for (int i = 0; i < 3; i++) begin
                r5_p1[i] <= PROD_W'($signed(r4_sum[i]) * $signed({1'b0, r4_dist}));
                r5_p2[i] <= (DIF_W+CW)'($signed(r4_dif[i]) * $signed(r4_k));
            end
            r6_d    <= r5_d;
            r6_dist <= r5_dist;
            r6_rad  <= r5_rad;
            for (int i = 0; i < 3; i++) begin
                r6_n[i] <= r5_p1[i]
                         + {{(PROD_W-DIF_W-CW){r5_p2[i][DIF_W+CW-1]}}, r5_p2[i]};
            end
        end
    end

    bsu_sqrt #(
        .N      (ROOT_N),
        .SIDE_W ($bits(t_in))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_sq    (r2_s),
        .i_side  (r2_d),
        .o_valid (sq_v),
        .o_root  (sq_dist),
        .o_side  (sq_d)
    );

    bsu_div #(
        .NW (NUM_W), .DW (DEN_W), .QW (QUO_W), .SIDE_W (TAIL_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (dv_num[0]),
        .i_den   (dv_den),
        .i_side  (dv_tail),
        .o_valid (q_vx),
        .o_quo   (q_quo[0]),
        .o_side  (q_tail)
    );

    bsu_div #(
        .NW (NUM_W), .DW (DEN_W), .QW (QUO_W), .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (dv_num[1]),
        .i_den   (dv_den),
        .i_side  (r6_n[1][PROD_W-1]),
        .o_valid (q_vy),
        .o_quo   (q_quo[1]),
        .o_side  (q_negy)
    );

    bsu_div #(
        .NW (NUM_W), .DW (DEN_W), .QW (QUO_W), .SIDE_W (1)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_v),
        .i_num   (dv_num[2]),
        .i_den   (dv_den),
        .i_side  (r6_n[2][PROD_W-1]),
        .o_valid (q_vz),
        .o_quo   (q_quo[2]),
        .o_side  (q_negz)
    );

    // the three dividers run in lockstep
    assign q_v = q_vx && q_vy && q_vz;

    // apply sign, clamp, and pick the empty-sphere and coincident cases
    always_comb begin
        localparam logic signed [QUO_W:0] VMAX = {{(QUO_W-CW+2){1'b0}}, {(CW-1){1'b1}}};
        localparam logic signed [QUO_W:0] VMIN = {{(QUO_W-CW+1){1'b1}}, 1'b1,
                                                  {(CW-1){1'b0}}};
        logic              ng [3];
        logic signed [QUO_W:0] sv [3];
        t_vec              ca;
        ng[0] = q_tail.neg;
        ng[1] = q_negy;
        ng[2] = q_negz;
        ca    = center_a(q_tail.data);
        for (int i = 0; i < 3; i++) begin
            sv[i] = ng[i] ? -$signed({1'b0, q_quo[i]}) : $signed({1'b0, q_quo[i]});
            if (q_tail.dzero)      fin_c[i] = ca[i];
            else if (sv[i] > VMAX) fin_c[i] = VMAX[CW-1:0];
            else if (sv[i] < VMIN) fin_c[i] = VMIN[CW-1:0];
            else                   fin_c[i] = sv[i][CW-1:0];
        end
        priority if (q_tail.data.a_radius == '0) begin
            fin_w.union_center_x = q_tail.data.b_center_x;
            fin_w.union_center_y = q_tail.data.b_center_y;
            fin_w.union_center_z = q_tail.data.b_center_z;
            fin_w.union_radius   = q_tail.data.b_radius;
        end else if (q_tail.data.b_radius == '0) begin
            fin_w.union_center_x = q_tail.data.a_center_x;
            fin_w.union_center_y = q_tail.data.a_center_y;
            fin_w.union_center_z = q_tail.data.a_center_z;
            fin_w.union_radius   = q_tail.data.a_radius;
        end else begin
            fin_w.union_center_x = fin_c[0];
            fin_w.union_center_y = fin_c[1];
            fin_w.union_center_z = fin_c[2];
            fin_w.union_radius   = q_tail.rad;
        end
    end

    // output register with one-word skid
    assign push  = en && q_v;
    assign space = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (space) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (space) begin
            r_out_data <= r_skid_valid ? r_skid_data : fin_w;
        end else if (push) begin
            r_skid_data <= fin_w;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

FILE: src/bsu_checker.sv
// Port-level checks for the bounding sphere union, bound to the top level.
// Depends on bsu_pkg and bounding_sphere_union.
module bsu_checker import bsu_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input backpressure only while a result waits
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // ready drops only after a refused output word
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");
endmodule

bind bounding_sphere_union bsu_checker u_bsu_checker (.*);
